// ===== hdl/assert_macros.svh =====
// assertion macros for the response parser checks
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define CHK_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CHK_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/sgrp_pkg.sv =====
// shared types and constants of the snmp get-response parser
// no dependencies
`default_nettype none

package sgrp_pkg;

	localparam int LEN_BITS_DEF = 16;
	localparam int VARBINDS     = 9;
	localparam int NUM_LEVELS   = 5;
	localparam int OUT_DEPTH    = 4;
	localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);
	localparam int IDX_W        = 4;
	localparam int TDATA_W      = 40;

	// level slots
	localparam logic [2:0] LVL_MSG   = 3'd0;
	localparam logic [2:0] LVL_VBIND = 3'd3;
	localparam logic [2:0] LVL_LEAF  = 3'd4;
	localparam logic [2:0] LVL_NONE  = 3'd7;

	// tags
	localparam logic [7:0] TAG_SEQ    = 8'h30;
	localparam logic [7:0] TAG_PDU    = 8'hA2;
	localparam logic [7:0] TAG_OCTETS = 8'h04;
	localparam logic [7:0] TAG_INT    = 8'h02;

	// verdict codes
	localparam logic [1:0] VERDICT_OK      = 2'd0;
	localparam logic [1:0] VERDICT_LENGTH  = 2'd1;
	localparam logic [1:0] VERDICT_TAG     = 2'd2;
	localparam logic [1:0] VERDICT_ERRSTAT = 2'd3;

	typedef struct packed {
		logic              is_status;
		logic [IDX_W-1:0]  var_index;
		logic              value_is_float;
		logic [31:0]       value_bits;
		logic [1:0]        verdict;
	} res_t;

	// results of one step, at most a value item then a verdict item
	typedef struct packed {
		logic push0;
		res_t item0;
		logic push1;
		res_t item1;
	} res_pair_t;

endpackage

`default_nettype wire

// ===== hdl/sgrp_outq.sv =====
// result queue: shift queue taking up to two items per cycle, one out
// depends on sgrp_pkg
`default_nettype none

module sgrp_outq import sgrp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire res_pair_t            pair,
	input  wire logic                 pop_ready,
	output res_t                      head,
	output logic [OUT_CNT_W-1:0]      count
);

	res_t                  q_q [OUT_DEPTH];
	res_t                  q_d [OUT_DEPTH];
	logic [OUT_CNT_W-1:0]  cnt_q;
	logic [OUT_CNT_W-1:0]  cnt_d;
	logic [OUT_CNT_W-1:0]  n0;
	logic [OUT_CNT_W-1:0]  n1;
	logic                  pop;

	assign pop   = pop_ready && (cnt_q != '0);
	assign head  = q_q[0];
	assign count = cnt_q;

	always_comb begin
		q_d = q_q;
		n0  = cnt_q;
		if (pop) begin
			for (int i = 0; i < OUT_DEPTH - 1; i++) begin
				q_d[i] = q_q[i + 1];
			end
			n0 = cnt_q - 1'b1;
		end
		for (int i = 0; i < OUT_DEPTH; i++) begin
			if (pair.push0 && (OUT_CNT_W'(i) == n0)) begin
				q_d[i] = pair.item0;
			end
		end
		n1 = n0 + OUT_CNT_W'(pair.push0);
		for (int i = 0; i < OUT_DEPTH; i++) begin
			if (pair.push1 && (OUT_CNT_W'(i) == n1)) begin
				q_d[i] = pair.item1;
			end
		end
		cnt_d = n1 + OUT_CNT_W'(pair.push1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_d;
	end

endmodule

`default_nettype wire

// ===== hdl/sgrp_core.sv =====
// tlv walker: parse state and one-byte step, emits value and verdict items
// depends on sgrp_pkg
`default_nettype none

module sgrp_core import sgrp_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step_go,
	input  wire logic [7:0]  byte_in,
	input  wire logic        last_in,
	output res_pair_t        pair
);

	typedef enum logic [3:0] {
		ST_MSG, ST_VERSION, ST_COMMUNITY, ST_PDU, ST_REQID, ST_ERRSTAT,
		ST_ERRINDEX, ST_VBL, ST_VARBIND, ST_OID, ST_VALUE, ST_TAIL,
		ST_DONE, ST_FAIL
	} stage_t;

	typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_LONG, PH_CONTENT} phase_t;

	typedef logic [NUM_LEVELS-1:0][LEN_BITS-1:0] lvl_t;

	stage_t            stage_q, st;
	phase_t            phase_q, ph;
	lvl_t              lvl_q, lv;
	logic [31:0]       lacc_q, lacc;
	logic [2:0]        lcnt_q, lcnt;
	logic [7:0]        tag_q, tag;
	logic [31:0]       vacc_q, vacc;
	logic [IDX_W-1:0]  vbc_q, vbc;
	logic [1:0]        fail_q, fc;

	logic              flt;
	logic [1:0]        flc;
	logic              hdone;
	logic              leafhdr;
	logic              leaf;
	logic              first;
	logic [2:0]        par;
	logic [LEN_BITS-1:0] prem;
	logic [1:0]        vd;
	res_pair_t         pair_c;

	function automatic logic [2:0] parent_of(input stage_t s);
		logic [2:0] r;
		case (s) inside
			ST_MSG: r = LVL_NONE;
			ST_VERSION, ST_COMMUNITY, ST_PDU: r = 3'd0;
			ST_REQID, ST_ERRSTAT, ST_ERRINDEX, ST_VBL: r = 3'd1;
			ST_VARBIND: r = 3'd2;
			default: r = LVL_VBIND;
		endcase
		return r;
	endfunction

	function automatic logic [LEN_BITS-1:0] lvl_at(input lvl_t l, input logic [2:0] p);
		logic [LEN_BITS-1:0] r;
		r = '0;
		for (int k = 0; k < NUM_LEVELS; k++) begin
			if (3'(k) == p) begin
				r = l[k];
			end
		end
		return r;
	endfunction

	function automatic lvl_t take_down(input lvl_t l, input logic [2:0] p);
		lvl_t r;
		r = l;
		for (int k = 0; k < NUM_LEVELS; k++) begin
			if ((p != LVL_NONE) && (3'(k) <= p) && (l[k] != '0)) begin
				r[k] = l[k] - 1'b1;
			end
		end
		return r;
	endfunction

	always_comb begin
		st      = stage_q;
		ph      = phase_q;
		lv      = lvl_q;
		lacc    = lacc_q;
		lcnt    = lcnt_q;
		tag     = tag_q;
		vacc    = vacc_q;
		vbc     = vbc_q;
		fc      = fail_q;
		flt     = 1'b0;
		flc     = VERDICT_OK;
		hdone   = 1'b0;
		leafhdr = 1'b0;
		leaf    = 1'b0;
		first   = 1'b0;
		par     = parent_of(stage_q);
		prem    = '0;
		vd      = VERDICT_OK;
		pair_c  = '0;

		if (st == ST_DONE || st == ST_FAIL) begin
			if (lv[LVL_MSG] != '0) begin
				lv[LVL_MSG] = lv[LVL_MSG] - 1'b1;
			end
		end else if (st == ST_TAIL) begin
			lv = take_down(lv, LVL_VBIND);
			if (lv[LVL_VBIND] == '0) begin
				st = ST_VARBIND;
			end
		end else if (ph == PH_CONTENT) begin
			// content byte of a leaf
			first = (lacc == 32'(lv[LVL_LEAF]));
			lv = take_down(lv, par);
			if (lv[LVL_LEAF] != '0) begin
				lv[LVL_LEAF] = lv[LVL_LEAF] - 1'b1;
			end
			if (st == ST_ERRSTAT) begin
				vacc = vacc | {24'd0, byte_in};
			end else if (st == ST_VALUE) begin
				if (tag == TAG_OCTETS) begin
					vacc = {byte_in, vacc[31:8]};
				end else if (first) begin
					vacc = {{24{byte_in[7]}}, byte_in};
				end else begin
					vacc = {vacc[23:0], byte_in};
				end
			end
			if (lv[LVL_LEAF] == '0) begin
				leaf = 1'b1;
			end
		end else begin
			// header byte
			if (par != LVL_NONE && lvl_at(lv, par) == '0) begin
				flt = 1'b1;
				flc = VERDICT_LENGTH;
			end else begin
				lv = take_down(lv, par);
				unique case (ph)
					PH_TAG: begin
						tag = byte_in;
						ph  = PH_LEN;
					end
					PH_LEN: begin
						if (byte_in[7]) begin
							if (byte_in[6:0] == 7'd0 || byte_in[6:0] > 7'd4) begin
								flt = 1'b1;
								flc = VERDICT_LENGTH;
							end else begin
								lcnt = byte_in[2:0];
								lacc = '0;
								ph   = PH_LONG;
							end
						end else begin
							lacc  = {24'd0, byte_in};
							hdone = 1'b1;
						end
					end
					default: begin
						lacc = {lacc[23:0], byte_in};
						lcnt = lcnt - 3'd1;
						if (lcnt == 3'd0) begin
							if (lacc[31]) begin
								flt = 1'b1;
								flc = VERDICT_LENGTH;
							end else begin
								hdone = 1'b1;
							end
						end
					end
				endcase
			end
		end

		if (hdone) begin
			ph   = PH_TAG;
			prem = lvl_at(lv, par);
			if (lacc[31:LEN_BITS] != '0) begin
				flt = 1'b1;
				flc = VERDICT_LENGTH;
			end else if (par != LVL_NONE && lacc[LEN_BITS-1:0] > prem) begin
				flt = 1'b1;
				flc = VERDICT_LENGTH;
			end else begin
				unique case (st)
					ST_MSG: begin
						lv[LVL_MSG] = lacc[LEN_BITS-1:0];
						if (tag != TAG_SEQ) begin
							flt = 1'b1;
							flc = VERDICT_TAG;
						end else begin
							st = ST_VERSION;
						end
					end
					ST_PDU: begin
						if (tag != TAG_PDU) begin
							flt = 1'b1;
							flc = VERDICT_TAG;
						end else begin
							lv[1] = lacc[LEN_BITS-1:0];
							st = ST_REQID;
						end
					end
					ST_VBL: begin
						if (tag != TAG_SEQ) begin
							flt = 1'b1;
							flc = VERDICT_TAG;
						end else begin
							lv[2] = lacc[LEN_BITS-1:0];
							st = ST_VARBIND;
						end
					end
					ST_VARBIND: begin
						if (tag != TAG_SEQ) begin
							flt = 1'b1;
							flc = VERDICT_TAG;
						end else begin
							lv[LVL_VBIND] = lacc[LEN_BITS-1:0];
							st = ST_OID;
						end
					end
					ST_ERRINDEX: begin
						if (vacc != '0) begin
							flt = 1'b1;
							flc = VERDICT_ERRSTAT;
						end else begin
							leafhdr = 1'b1;
						end
					end
					ST_VALUE: begin
						if (tag != TAG_OCTETS && tag != TAG_INT) begin
							flt = 1'b1;
							flc = VERDICT_TAG;
						end else begin
							vacc    = '0;
							leafhdr = 1'b1;
						end
					end
					default: begin
						vacc    = '0;
						leafhdr = 1'b1;
					end
				endcase
			end
			if (leafhdr) begin
				lv[LVL_LEAF] = lacc[LEN_BITS-1:0];
				if (lacc == '0) begin
					leaf = 1'b1;
				end else begin
					ph = PH_CONTENT;
				end
			end
		end

		if (leaf) begin
			ph = PH_TAG;
			unique case (st)
				ST_VERSION:   st = ST_COMMUNITY;
				ST_COMMUNITY: st = ST_PDU;
				ST_REQID:     st = ST_ERRSTAT;
				ST_ERRSTAT:   st = ST_ERRINDEX;
				ST_ERRINDEX:  st = ST_VBL;
				ST_OID:       st = ST_VALUE;
				ST_VALUE: begin
					pair_c.push0                = 1'b1;
					pair_c.item0.var_index      = vbc;
					pair_c.item0.value_is_float = (tag == TAG_OCTETS);
					pair_c.item0.value_bits =
						((tag == TAG_OCTETS) && (lacc != 32'd4)) ? '0 : vacc;
					if (({1'b0, vbc} + 5'd1) >= 5'(VARBINDS)) begin
						st = ST_DONE;
					end else begin
						vbc = vbc + 1'b1;
						st  = (lv[LVL_VBIND] != '0) ? ST_TAIL : ST_VARBIND;
					end
				end
				default: begin
				end
			endcase
		end

		if (flt) begin
			if (fc == VERDICT_OK) begin
				fc = flc;
			end
			st = ST_FAIL;
			ph = PH_TAG;
		end

		if (last_in) begin
			vd = (fc != VERDICT_OK) ? fc : ((st == ST_DONE) ? VERDICT_OK : VERDICT_LENGTH);
			if (lv[LVL_MSG] != '0) begin
				vd = VERDICT_LENGTH;
			end
			pair_c.push1           = 1'b1;
			pair_c.item1.is_status = 1'b1;
			pair_c.item1.verdict   = vd;
			st   = ST_MSG;
			ph   = PH_TAG;
			lv   = '0;
			lacc = '0;
			lcnt = '0;
			tag  = '0;
			vacc = '0;
			vbc  = '0;
			fc   = VERDICT_OK;
		end

		pair_c.push0 = pair_c.push0 && step_go;
		pair_c.push1 = pair_c.push1 && step_go;
	end

	assign pair = pair_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_MSG;
			phase_q <= PH_TAG;
			lvl_q   <= '0;
			lacc_q  <= '0;
			lcnt_q  <= '0;
			tag_q   <= '0;
			vacc_q  <= '0;
			vbc_q   <= '0;
			fail_q  <= VERDICT_OK;
		end else if (step_go) begin
			stage_q <= st;
			phase_q <= ph;
			lvl_q   <= lv;
			lacc_q  <= lacc;
			lcnt_q  <= lcnt;
			tag_q   <= tag;
			vacc_q  <= vacc;
			vbc_q   <= vbc;
			fail_q  <= fc;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/snmp_get_response_parser_unit.sv =====
// top level of the snmp get-response parser: input register, tlv walker, result queue
// depends on sgrp_pkg, sgrp_core, sgrp_outq and assert_macros.svh
//
//   channel   dir   carries
//   s_axis    in    one datagram byte per item, tlast on the final byte
//   m_axis    out   varbind value items, then the verdict item with tlast
//
// one byte per cycle while s_axis_tready is high; a taken byte is held in the input register until the queue has room
// a byte gives at most two items, drained one per cycle while m_axis_tready is high through a 4-entry queue
// s_axis_tready drops only while the queue holds more than two items
// reset clears the parse state, the valid flag of the input register and the queue count
`default_nettype none

`include "assert_macros.svh"

module snmp_get_response_parser_unit import sgrp_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,   // [7:0] data_byte
	input  wire logic               s_axis_tlast,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [TDATA_W-1:0]      m_axis_tdata,   // [3:0] var_index, [4] value_is_float,
	                                                // [36:5] value_bits, [38:37] verdict
	output logic                    m_axis_tlast
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  in_fire;
	logic                  room;
	logic                  step_go;
	res_pair_t             pair;
	res_t                  head;
	logic [OUT_CNT_W-1:0]  q_cnt;

	assign room          = (q_cnt <= OUT_CNT_W'(OUT_DEPTH - 2));
	assign step_go       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	sgrp_core #(
		.LEN_BITS(LEN_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_go (step_go),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.pair    (pair)
	);

	sgrp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.pop_ready (m_axis_tready),
		.head      (head),
		.count     (q_cnt)
	);

	assign m_axis_tvalid = (q_cnt != '0);
	assign m_axis_tlast  = head.is_status;
	assign m_axis_tdata  = {1'b0, head.verdict, head.value_bits, head.value_is_float,
		head.var_index};

	`CHK_NEVER(a_queue_bound, q_cnt > OUT_CNT_W'(OUT_DEPTH), "result queue overfilled")
	`CHK_HOLDS(a_verdict_on_last, pair.push1 |-> (step_go && last_s1), "verdict without last byte")
	`CHK_HOLDS(a_value_item_form, pair.push0 |-> (!pair.item0.is_status && pair.item0.verdict == VERDICT_OK), "bad value item")
	`CHK_HOLDS(a_input_held, in_fire |=> valid_s1, "accepted byte lost")

endmodule

`default_nettype wire

// ===== tb/sgrp_response_checker.sv =====
// response checker for the snmp get-response parser: watches both stream channels,
// predicts the value and verdict items of each accepted byte and compares them in order
// depends on sgrp_pkg
module sgrp_response_checker import sgrp_pkg::*; #(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	input  wire logic               byte_ready,
	input  wire logic [7:0]         byte_data,
	input  wire logic               byte_last,
	input  wire logic               item_valid,
	input  wire logic               item_ready,
	input  wire logic [TDATA_W-1:0] item_data,
	input  wire logic               item_last,
	output int                      mismatches,
	output int                      awaited,
	output int                      values_checked,
	output int                      verdicts_checked,
	output int                      clean_datagrams
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		ST_MSG, ST_VERSION, ST_COMMUNITY, ST_PDU, ST_REQID, ST_ERRSTAT, ST_ERRINDEX,
		ST_VBL, ST_VARBIND, ST_OID, ST_VALUE, ST_TAIL, ST_DONE, ST_FAIL
	} stage_e;

	typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_LONG, PH_CONTENT} phase_e;

	localparam logic [2:0]  LVL_PDU   = 3'd1;
	localparam logic [2:0]  LVL_LIST  = 3'd2;
	localparam logic [31:0] LEN_LIMIT = 32'((64'd1 << LEN_BITS) - 1);

	stage_e      stage;
	phase_e      hphase;
	int unsigned remain [NUM_LEVELS];
	logic [31:0] len_acc;
	logic [2:0]  long_cnt;
	logic [7:0]  cur_tag;
	logic [31:0] val_acc;
	logic [3:0]  vb_idx;
	logic [1:0]  fail_code;

	res_t awaited_items[$];
	int   err_count;
	int   value_count;
	int   verdict_count;
	int   ok_count;

	function automatic void clear_parse();
		stage = ST_MSG;
		hphase = PH_TAG;
		foreach (remain[i]) remain[i] = 0;
		len_acc = '0;
		long_cnt = '0;
		cur_tag = '0;
		val_acc = '0;
		vb_idx = '0;
		fail_code = VERDICT_OK;
	endfunction

	function automatic void fail(logic [1:0] code);
		if (fail_code == VERDICT_OK) fail_code = code;
		stage = ST_FAIL;
		hphase = PH_TAG;
	endfunction

	// level whose content holds a tlv of this stage
	function automatic logic [2:0] parent_of(stage_e st);
		case (st)
			ST_MSG: return LVL_NONE;
			ST_VERSION, ST_COMMUNITY, ST_PDU: return LVL_MSG;
			ST_REQID, ST_ERRSTAT, ST_ERRINDEX, ST_VBL: return LVL_PDU;
			ST_VARBIND: return LVL_LIST;
			default: return LVL_VBIND;
		endcase
	endfunction

	function automatic void take_down(logic [2:0] p);
		int i;
		for (i = 0; i <= int'(p) && i < NUM_LEVELS; i++)
			if (remain[i] > 0) remain[i]--;
	endfunction

	function automatic void expect_item(logic status, logic [3:0] idx, logic isf,
			logic [31:0] bits, logic [1:0] verdict);
		res_t r;
		r.is_status = status;
		r.var_index = idx;
		r.value_is_float = isf;
		r.value_bits = bits;
		r.verdict = verdict;
		awaited_items.push_back(r);
	endfunction

	function automatic void leaf_end();
		logic        isf;
		logic [31:0] bits;
		hphase = PH_TAG;
		case (stage)
			ST_VERSION: stage = ST_COMMUNITY;
			ST_COMMUNITY: stage = ST_PDU;
			ST_REQID: stage = ST_ERRSTAT;
			ST_ERRSTAT: stage = ST_ERRINDEX;
			ST_ERRINDEX: stage = ST_VBL;
			ST_OID: stage = ST_VALUE;
			ST_VALUE: begin
				isf = (cur_tag == TAG_OCTETS);
				bits = val_acc;
				if (isf && len_acc != 32'd4) bits = '0;
				expect_item(1'b0, vb_idx, isf, bits, VERDICT_OK);
				if (int'(vb_idx) + 1 >= VARBINDS) begin
					stage = ST_DONE;
				end else begin
					vb_idx = vb_idx + 1'b1;
					stage = (remain[LVL_VBIND] > 0) ? ST_TAIL : ST_VARBIND;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void header_done();
		logic [31:0] len;
		logic [2:0]  p;
		len = len_acc;
		p = parent_of(stage);
		hphase = PH_TAG;
		if (len > LEN_LIMIT) begin
			fail(VERDICT_LENGTH);
			return;
		end
		if (p != LVL_NONE && len > remain[p]) begin
			fail(VERDICT_LENGTH);
			return;
		end
		case (stage)
			ST_MSG: begin
				remain[LVL_MSG] = len;
				if (cur_tag != TAG_SEQ) fail(VERDICT_TAG);
				else stage = ST_VERSION;
				return;
			end
			ST_PDU: begin
				if (cur_tag != TAG_PDU) begin
					fail(VERDICT_TAG);
				end else begin
					remain[LVL_PDU] = len;
					stage = ST_REQID;
				end
				return;
			end
			ST_VBL: begin
				if (cur_tag != TAG_SEQ) begin
					fail(VERDICT_TAG);
				end else begin
					remain[LVL_LIST] = len;
					stage = ST_VARBIND;
				end
				return;
			end
			ST_VARBIND: begin
				if (cur_tag != TAG_SEQ) begin
					fail(VERDICT_TAG);
				end else begin
					remain[LVL_VBIND] = len;
					stage = ST_OID;
				end
				return;
			end
			ST_ERRINDEX: begin
				if (val_acc != '0) begin
					fail(VERDICT_ERRSTAT);
					return;
				end
			end
			ST_VALUE: begin
				if (cur_tag != TAG_OCTETS && cur_tag != TAG_INT) begin
					fail(VERDICT_TAG);
					return;
				end
				val_acc = '0;
			end
			default: val_acc = '0;
		endcase
		remain[LVL_LEAF] = len;
		if (len == '0) leaf_end();
		else hphase = PH_CONTENT;
	endfunction

	function automatic void content_byte(logic [7:0] b);
		logic lead;
		lead = (remain[LVL_LEAF] == len_acc);
		take_down(parent_of(stage));
		if (remain[LVL_LEAF] > 0) remain[LVL_LEAF]--;
		if (stage == ST_ERRSTAT) begin
			val_acc = val_acc | {24'h0, b};
		end else if (stage == ST_VALUE) begin
			if (cur_tag == TAG_OCTETS) val_acc = {b, val_acc[31:8]};
			else if (lead) val_acc = {{24{b[7]}}, b};
			else val_acc = {val_acc[23:0], b};
		end
		if (remain[LVL_LEAF] == 0) leaf_end();
	endfunction

	function automatic void header_byte(logic [7:0] b);
		logic [2:0] p;
		p = parent_of(stage);
		if (p != LVL_NONE) begin
			if (remain[p] == 0) begin
				fail(VERDICT_LENGTH);
				return;
			end
			take_down(p);
		end
		if (hphase == PH_TAG) begin
			cur_tag = b;
			hphase = PH_LEN;
		end else if (hphase == PH_LEN) begin
			if (b[7]) begin
				if (b[6:0] == 7'd0 || b[6:0] > 7'd4) begin
					fail(VERDICT_LENGTH);
					return;
				end
				long_cnt = b[2:0];
				len_acc = '0;
				hphase = PH_LONG;
			end else begin
				len_acc = {24'h0, b};
				header_done();
			end
		end else begin
			len_acc = {len_acc[23:0], b};
			long_cnt = long_cnt - 3'd1;
			if (long_cnt == 3'd0) begin
				if (len_acc[31]) begin
					fail(VERDICT_LENGTH);
					return;
				end
				header_done();
			end
		end
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic last);
		logic [1:0] v;
		if (stage == ST_DONE || stage == ST_FAIL) begin
			if (remain[LVL_MSG] > 0) remain[LVL_MSG]--;
		end else if (stage == ST_TAIL) begin
			take_down(LVL_VBIND);
			if (remain[LVL_VBIND] == 0) stage = ST_VARBIND;
		end else if (hphase == PH_CONTENT) begin
			content_byte(b);
		end else begin
			header_byte(b);
		end
		if (last) begin
			if (fail_code != VERDICT_OK) v = fail_code;
			else v = (stage == ST_DONE) ? VERDICT_OK : VERDICT_LENGTH;
			if (remain[LVL_MSG] > 0) v = VERDICT_LENGTH;
			expect_item(1'b1, 4'd0, 1'b0, 32'd0, v);
			clear_parse();
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			err_count++;
		end
	endfunction

	function automatic void compare_item();
		res_t want;
		if (awaited_items.size() == 0) begin
			$error("item with nothing pending: tdata %h tlast %b", item_data, item_last);
			err_count++;
			return;
		end
		want = awaited_items.pop_front();
		check_field("is_status", 32'(want.is_status), 32'(item_last));
		check_field("var_index", 32'(want.var_index), 32'(item_data[3:0]));
		check_field("value_is_float", 32'(want.value_is_float), 32'(item_data[4]));
		check_field("value_bits", want.value_bits, item_data[36:5]);
		check_field("verdict", 32'(want.verdict), 32'(item_data[38:37]));
		check_field("tdata pad", 32'd0, 32'(item_data[TDATA_W-1:39]));
		if (want.is_status) begin
			verdict_count++;
			if (want.verdict == VERDICT_OK) ok_count++;
		end else begin
			value_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			awaited_items.delete();
			err_count = 0;
			value_count = 0;
			verdict_count = 0;
			ok_count = 0;
		end else begin
			if (byte_valid && byte_ready) parse_byte(byte_data, byte_last);
			if (item_valid && item_ready) compare_item();
		end
		mismatches <= err_count;
		awaited <= awaited_items.size();
		values_checked <= value_count;
		verdicts_checked <= verdict_count;
		clean_datagrams <= ok_count;
	end

endmodule

// ===== tb/tb_top.sv =====
// top of the snmp get-response parser testbench: clock, reset, datagram stimulus and verdict
// drives short malformed datagrams and one good response, then random responses under changing idling and back-pressure
// depends on sgrp_pkg, snmp_get_response_parser_unit and sgrp_response_checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sgrp_pkg::*;

	typedef logic [7:0] bytes_t[$];

	typedef enum {
		RSP_GOOD, RSP_ERRSTAT, RSP_BAD_TAG, RSP_SHORT_LIST, RSP_TRUNCATED, RSP_MUTATED, RSP_NOISE
	} rsp_kind_e;

	localparam int TOTAL_BYTES  = 1100;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int N_DIRECTED   = 11;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = '0;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tlast;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int datagrams = 0;

	int mismatches;
	int awaited;
	int values_checked;
	int verdicts_checked;
	int clean_datagrams;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	snmp_get_response_parser_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	sgrp_response_checker #(.LEN_BITS(LEN_BITS_DEF)) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (s_axis_tvalid),
		.byte_ready      (s_axis_tready),
		.byte_data       (s_axis_tdata),
		.byte_last       (s_axis_tlast),
		.item_valid      (m_axis_tvalid),
		.item_ready      (m_axis_tready),
		.item_data       (m_axis_tdata),
		.item_last       (m_axis_tlast),
		.mismatches      (mismatches),
		.awaited         (awaited),
		.values_checked  (values_checked),
		.verdicts_checked(verdicts_checked),
		.clean_datagrams (clean_datagrams)
	);

	// long receiver hold-off, restarted on each new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
	end

	function automatic bytes_t rand_bytes(int n);
		bytes_t r;
		repeat (n) r.push_back(8'($urandom));
		return r;
	endfunction

	function automatic bytes_t extra_bytes();
		bytes_t r;
		if ($urandom_range(4) == 0) r = rand_bytes($urandom_range(1, 3));
		return r;
	endfunction

	// short or long form, long form sometimes with leading zero bytes
	function automatic bytes_t enc_len(int unsigned n);
		bytes_t r;
		int     nb;
		int     i;
		if (n < 128 && $urandom_range(3) != 0) begin
			r.push_back(n[7:0]);
		end else begin
			nb = 1;
			while (nb < 4 && (n >> (8 * nb)) != 0) nb++;
			nb = $urandom_range(4, nb);
			r.push_back(8'h80 | 8'(nb));
			for (i = nb - 1; i >= 0; i--) r.push_back(8'(n >> (8 * i)));
		end
		return r;
	endfunction

	function automatic bytes_t tlv(logic [7:0] tag, bytes_t body);
		bytes_t r;
		r = enc_len(body.size());
		r.push_front(tag);
		r = {r, body};
		return r;
	endfunction

	function automatic logic [7:0] flip_bit(logic [7:0] tag);
		return tag ^ (8'h01 << $urandom_range(7));
	endfunction

	function automatic bytes_t make_response(rsp_kind_e kind);
		bytes_t     vbl, vb, val, pdu, msg, d, es, ver;
		int         nvb, bad_at, bad_vb, k, n;
		logic [7:0] vtag;
		bad_at = (kind == RSP_BAD_TAG) ? $urandom_range(4) : -1;
		bad_vb = $urandom_range(VARBINDS - 1);
		if (kind == RSP_SHORT_LIST) nvb = $urandom_range(VARBINDS - 1);
		else nvb = VARBINDS + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
		for (k = 0; k < nvb; k++) begin
			if ($urandom_range(1) == 1) begin
				vtag = TAG_OCTETS;
				n = ($urandom_range(4) == 0) ? $urandom_range(7) : 4;
			end else begin
				vtag = TAG_INT;
				n = ($urandom_range(7) == 0) ? $urandom_range(6) : $urandom_range(1, 4);
			end
			if (bad_at == 4 && k == bad_vb) vtag = flip_bit(vtag);
			val = tlv(vtag, rand_bytes(n));
			vb = tlv(8'h06, rand_bytes($urandom_range(3)));
			vb = {vb, val, extra_bytes()};
			vbl = {vbl, tlv((bad_at == 3 && k == bad_vb) ? flip_bit(TAG_SEQ) : TAG_SEQ, vb)};
		end
		vbl = {vbl, extra_bytes()};
		n = $urandom_range(1, 2);
		if (kind == RSP_ERRSTAT) begin
			es = rand_bytes(n);
			es[$urandom_range(n - 1)] = 8'($urandom_range(1, 255));
		end else begin
			repeat (n) es.push_back(8'h00);
		end
		pdu = tlv(TAG_INT, rand_bytes($urandom_range(1, 4)));
		pdu = {pdu, tlv(TAG_INT, es), tlv(TAG_INT, rand_bytes(1))};
		pdu = {pdu, tlv((bad_at == 2) ? flip_bit(TAG_SEQ) : TAG_SEQ, vbl), extra_bytes()};
		ver.push_back(8'h00);
		msg = tlv(($urandom_range(7) == 0) ? 8'($urandom) : TAG_INT, ver);
		msg = {msg, tlv(TAG_OCTETS, rand_bytes($urandom_range(6)))};
		msg = {msg, tlv((bad_at == 1) ? flip_bit(TAG_PDU) : TAG_PDU, pdu), extra_bytes()};
		d = tlv((bad_at == 0) ? flip_bit(TAG_SEQ) : TAG_SEQ, msg);
		d = {d, extra_bytes()};
		if (kind == RSP_TRUNCATED) begin
			n = $urandom_range(1, d.size() - 1);
			while (d.size() > n) void'(d.pop_back());
		end else if (kind == RSP_MUTATED) begin
			d[$urandom_range(d.size() - 1)] = 8'($urandom);
		end
		return d;
	endfunction

	function automatic rsp_kind_e pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 55) return RSP_GOOD;
		if (r < 62) return RSP_ERRSTAT;
		if (r < 69) return RSP_BAD_TAG;
		if (r < 74) return RSP_SHORT_LIST;
		if (r < 82) return RSP_TRUNCATED;
		if (r < 92) return RSP_MUTATED;
		return RSP_NOISE;
	endfunction

	task automatic send_byte(logic [7:0] b, logic last);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_datagram(bytes_t d);
		int i;
		for (i = 0; i < d.size(); i++) send_byte(d[i], i == d.size() - 1);
		bytes_sent += d.size();
		datagrams++;
	endtask

	initial begin
		bytes_t    d;
		int        k;
		int        phase;
		int        base;
		int        phase_end;
		rsp_kind_e kind;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < N_DIRECTED; k++) begin
			case (k)
				0: d = {8'h00};
				1: d = {8'hFF};
				2: d = {TAG_SEQ, 8'h80};
				3: d = {TAG_SEQ, 8'h85, 8'h00};
				4: d = {8'h31, 8'h00};
				5: d = {TAG_SEQ, 8'h84, 8'h80, 8'h00, 8'h00, 8'h00};
				6: d = {TAG_SEQ, 8'h83, 8'h01, 8'h00, 8'h00};
				7: d = {TAG_SEQ, 8'h82, 8'hFF, 8'hFF};
				8: d = {TAG_SEQ, 8'h03, TAG_INT, 8'h05, 8'h00};
				9: d = {TAG_SEQ, 8'h00, 8'h7F};
				default: d = {TAG_SEQ, 8'h02, TAG_INT, 8'h00, TAG_INT};
			endcase
			send_datagram(d);
		end
		send_datagram(make_response(RSP_GOOD));
		base = bytes_sent;

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct <= 0;  end
				1: begin idle_pct = 64; stall_pct <= 0;  end
				2: begin idle_pct = 0;  stall_pct <= 64; end
				default: begin idle_pct = 26; stall_pct <= 26; end
			endcase
			if (phase == 0 || phase == 3) hold_req <= hold_req + 1;
			phase_end = base + ((phase + 1) * (TOTAL_BYTES - base)) / 4;
			while (bytes_sent < phase_end) begin
				kind = pick_kind();
				if (kind == RSP_NOISE) d = rand_bytes($urandom_range(1, 16));
				else d = make_response(kind);
				send_datagram(d);
			end
		end

		s_axis_tvalid <= 1'b0;
		stall_pct <= 0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d datagrams under four idling phases and two hold-offs",
			bytes_sent, datagrams);
		$display("checked %0d value items and %0d verdicts, %0d datagrams parsed clean",
			values_checked, verdicts_checked, clean_datagrams);
		if (mismatches == 0 && awaited == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", awaited);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
